// ===== rtl/tcw_pkg.sv =====
// shared codes, control word layout and microprogram of the text console writer
package tcw_pkg;

    // input actions
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // blank cell left by scroll and clear (attribute zero)
    localparam logic [15:0] PLAIN_BLANK = 16'h0020;

    // configuration register indexes and reset values
    localparam logic       CFG_FOREGROUND = 1'b0;
    localparam logic       CFG_BACKGROUND = 1'b1;
    localparam logic [3:0] FG_RESET       = 4'd7;
    localparam logic [3:0] BG_RESET       = 4'd0;

    // kind of character being put
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_LITERAL = 2'd0;
    localparam kind_t KIND_NEWLINE = 2'd1;
    localparam kind_t KIND_TAB     = 2'd2;

    // microprogram addresses
    typedef logic [3:0] upc_t;
    localparam upc_t U_IDLE  = 4'd0;
    localparam upc_t U_PFULL = 4'd1;
    localparam upc_t U_PWR   = 4'd2;
    localparam upc_t U_PTEST = 4'd3;
    localparam upc_t U_DONE  = 4'd4;
    localparam upc_t U_SC0   = 4'd5;
    localparam upc_t U_SC1   = 4'd6;
    localparam upc_t U_SC2   = 4'd7;
    localparam upc_t U_SC3   = 4'd8;
    localparam upc_t U_SC4   = 4'd9;
    localparam upc_t U_CLR0  = 4'd10;
    localparam upc_t U_CLR1  = 4'd11;
    localparam upc_t U_CLR2  = 4'd12;
    localparam upc_t U_RD0   = 4'd13;
    localparam upc_t U_RD1   = 4'd14;

    // store write select
    localparam logic [1:0] WS_NONE  = 2'd0;
    localparam logic [1:0] WS_CHAR  = 2'd1;
    localparam logic [1:0] WS_COPY  = 2'd2;
    localparam logic [1:0] WS_BLANK = 2'd3;

    // pointer setup
    localparam logic [1:0] PO_HOLD   = 2'd0;
    localparam logic [1:0] PO_SCROLL = 2'd1;
    localparam logic [1:0] PO_CLEAR  = 2'd2;

    // cursor update
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_INC  = 2'd1;
    localparam logic [1:0] CO_LAST = 2'd2;
    localparam logic [1:0] CO_HOME = 2'd3;

    // jump conditions; a false condition falls through to the next step, but dispatch and output wait in place
    localparam logic [2:0] CD_NEXT     = 3'd0;
    localparam logic [2:0] CD_ALWAYS   = 3'd1;
    localparam logic [2:0] CD_DISPATCH = 3'd2;
    localparam logic [2:0] CD_FULL     = 3'd3;
    localparam logic [2:0] CD_MORE     = 3'd4;
    localparam logic [2:0] CD_COPY     = 3'd5;
    localparam logic [2:0] CD_FILL     = 3'd6;
    localparam logic [2:0] CD_OUT      = 3'd7;

    typedef struct packed {
        logic [1:0] wsel;
        logic       rd_en;
        logic [1:0] ptr_op;
        logic [1:0] cur_op;
        logic       cnt_inc;
        logic       cell_cap;
        logic [2:0] cond;
        upc_t       target;
    } uword_t;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '{wsel: WS_NONE, rd_en: 1'b0, ptr_op: PO_HOLD, cur_op: CO_HOLD,
              cnt_inc: 1'b0, cell_cap: 1'b0, cond: CD_NEXT, target: U_IDLE};
        unique case (pc)
            U_IDLE: begin
                w.cond = CD_DISPATCH;
            end
            U_PFULL: begin
                w.cond   = CD_FULL;
                w.target = U_SC0;
            end
            U_PWR: begin
                w.wsel    = WS_CHAR;
                w.cur_op  = CO_INC;
                w.cnt_inc = 1'b1;
            end
            U_PTEST: begin
                w.cond   = CD_MORE;
                w.target = U_PFULL;
            end
            U_DONE: begin
                w.cond   = CD_OUT;
                w.target = U_IDLE;
            end
            U_SC0: begin
                w.ptr_op = PO_SCROLL;
            end
            U_SC1: begin
                w.rd_en = 1'b1;
            end
            U_SC2: begin
                // read one row ahead while writing the cell read last cycle
                w.rd_en  = 1'b1;
                w.wsel   = WS_COPY;
                w.cond   = CD_COPY;
                w.target = U_SC2;
            end
            U_SC3: begin
                w.wsel   = WS_BLANK;
                w.cond   = CD_FILL;
                w.target = U_SC3;
            end
            U_SC4: begin
                w.cur_op = CO_LAST;
                w.cond   = CD_ALWAYS;
                w.target = U_PWR;
            end
            U_CLR0: begin
                w.ptr_op = PO_CLEAR;
                w.cur_op = CO_HOME;
            end
            U_CLR1: begin
                w.wsel   = WS_BLANK;
                w.cond   = CD_FILL;
                w.target = U_CLR1;
            end
            U_CLR2: begin
                w.cond   = CD_ALWAYS;
                w.target = U_DONE;
            end
            U_RD0: begin
                w.rd_en = 1'b1;
            end
            U_RD1: begin
                w.cell_cap = 1'b1;
                w.cond     = CD_ALWAYS;
                w.target   = U_DONE;
            end
            default: begin
                w.cond   = CD_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tcw_screen_ram.sv =====
// screen store: one write port, one read port with registered read data
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] store_reg [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// text console writer: microcoded sequencer over a cell store with a linear cursor
// a put of a plain character writes one cell and a newline or tab writes blanks; a read
//   fetches one cell and a clear blanks every cell of the store
// a scroll copies the store up one row, moving one cell per cycle over the store port
// one item at a time; a new item is taken while the previous result waits at the output
// reset: cursor home, colours 7 on 0, output empty; store contents undefined until written
module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_char_code,
    input  logic [10:0] s_cell_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_cursor_position,
    output logic [15:0] m_cell_word
);
    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int LAST     = CELLS - COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int CURW     = $clog2(CELLS + 1);
    localparam int COLW     = $clog2(COLUMNS);
    localparam int TABW     = $clog2(TAB_STOP + 1);
    localparam int CNTW     = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int LAST_TAB = LAST % TAB_STOP;

    uword_t          uw;
    upc_t            upc_reg, upc_next;
    logic [CURW-1:0] cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [TABW-1:0] tab_reg, tab_next;
    logic [CNTW-1:0] cnt_reg;
    kind_t           kind_reg;
    logic [7:0]      char_reg;
    logic [CURW-1:0] rd_ptr_reg;
    logic [AW-1:0]   wr_ptr_reg;
    logic            in_range_reg;
    logic [15:0]     cell_reg;
    logic [3:0]      fg_reg, bg_reg;
    logic            m_valid_reg;
    logic [10:0]     m_cursor_reg;
    logic [15:0]     m_cell_reg;

    logic            accept, out_free, full, more, copy_more, fill_more;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata, mem_rdata;
    logic [CURW+10:0] idx_ext, cur_ext;

    assign uw       = ucode(upc_reg);
    assign s_ready  = (upc_reg == U_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign idx_ext = {{CURW{1'b0}}, s_cell_index};
    assign cur_ext = {11'b0, cursor_reg};

    assign full      = (cursor_reg == CURW'(CELLS));
    assign copy_more = (wr_ptr_reg != AW'(LAST - 1));
    assign fill_more = (wr_ptr_reg != AW'(CELLS - 1));

    always_comb begin
        case (kind_reg)
            KIND_NEWLINE: more = (col_reg != '0) && (cnt_reg < CNTW'(COLUMNS));
            KIND_TAB:     more = (tab_reg != '0) && (cnt_reg < CNTW'(COLUMNS + TAB_STOP));
            default:      more = 1'b0;
        endcase
    end

    // next step of the microprogram
    always_comb begin
        upc_next = upc_t'(upc_reg + 1'b1);
        unique case (uw.cond)
            CD_NEXT:   upc_next = upc_t'(upc_reg + 1'b1);
            CD_ALWAYS: upc_next = uw.target;
            CD_DISPATCH: begin
                if (!accept) begin
                    upc_next = upc_reg;
                end else begin
                    case (s_action)
                        ACT_PUT:   upc_next = U_PFULL;
                        ACT_CLEAR: upc_next = U_CLR0;
                        ACT_READ:  upc_next = U_RD0;
                        default:   upc_next = U_DONE;
                    endcase
                end
            end
            CD_FULL: if (full) upc_next = uw.target;
            CD_MORE: if (more) upc_next = uw.target;
            CD_COPY: if (copy_more) upc_next = uw.target;
            CD_FILL: if (fill_more) upc_next = uw.target;
            CD_OUT:  upc_next = out_free ? uw.target : upc_reg;
            default: upc_next = U_IDLE;
        endcase
    end

    // cursor with its column and tab phase kept alongside
    always_comb begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        tab_next    = tab_reg;
        unique case (uw.cur_op)
            CO_HOLD: begin
            end
            CO_INC: begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                tab_next    = (tab_reg == TABW'(TAB_STOP - 1)) ? '0 : tab_reg + 1'b1;
            end
            CO_LAST: begin
                cursor_next = CURW'(LAST);
                col_next    = '0;
                tab_next    = TABW'(LAST_TAB);
            end
            CO_HOME: begin
                cursor_next = '0;
                col_next    = '0;
                tab_next    = '0;
            end
            default: begin
            end
        endcase
    end

    // store write port
    always_comb begin
        mem_we    = (uw.wsel != WS_NONE);
        mem_waddr = wr_ptr_reg;
        mem_wdata = PLAIN_BLANK;
        case (uw.wsel)
            WS_CHAR: begin
                mem_waddr = cursor_reg[AW-1:0];
                mem_wdata = {bg_reg, fg_reg,
                             (kind_reg == KIND_LITERAL) ? char_reg : CHAR_SPACE};
            end
            WS_COPY: mem_wdata = mem_rdata;
            default: mem_wdata = PLAIN_BLANK;
        endcase
    end

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (uw.rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= U_IDLE;
            cursor_reg  <= '0;
            col_reg     <= '0;
            tab_reg     <= '0;
            fg_reg      <= FG_RESET;
            bg_reg      <= BG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg    <= upc_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            tab_reg    <= tab_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FOREGROUND: fg_reg <= cfg_wr_data;
                    CFG_BACKGROUND: bg_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (uw.cond == CD_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg     <= s_char_code;
            cnt_reg      <= '0;
            cell_reg     <= '0;
            rd_ptr_reg   <= idx_ext[CURW-1:0];
            in_range_reg <= (idx_ext < (CURW + 11)'(CELLS));
            if (s_char_code == CHAR_NEWLINE) begin
                kind_reg <= KIND_NEWLINE;
            end else if (s_char_code == CHAR_TAB) begin
                kind_reg <= KIND_TAB;
            end else begin
                kind_reg <= KIND_LITERAL;
            end
        end
        if (uw.ptr_op == PO_SCROLL) begin
            rd_ptr_reg <= CURW'(COLUMNS);
            wr_ptr_reg <= '0;
        end else if (uw.ptr_op == PO_CLEAR) begin
            wr_ptr_reg <= '0;
        end
        if (uw.rd_en) begin
            rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
        if (uw.wsel == WS_COPY || uw.wsel == WS_BLANK) begin
            wr_ptr_reg <= wr_ptr_reg + 1'b1;
        end
        if (uw.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (uw.cell_cap) begin
            cell_reg <= in_range_reg ? mem_rdata : '0;
        end
        if (uw.cond == CD_OUT && out_free) begin
            m_cursor_reg <= cur_ext[10:0];
            m_cell_reg   <= cell_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = m_cursor_reg;
    assign m_cell_word       = m_cell_reg;

    // not ready again in the cycle after taking an item
    ap_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("sequencer ready right after a transfer");

    ap_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= CURW'(CELLS))
        else $error("cursor beyond end of screen");

    ap_write_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(CELLS)))
        else $error("store write outside the screen");

    ap_column_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < (COLW + 1)'(COLUMNS) && tab_reg < TABW'(TAB_STOP))
        else $error("column or tab phase out of range");

endmodule

// ===== sim/text_console_writer_test.sv =====
// testbench for the text console writer: directed table, random text phases, cell-store predictor
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int TAB_STOP       = 4;
    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 52;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  ch;
        logic [10:0] idx;
    } console_item_t;

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] word;
    } console_reply_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic        typed;
        logic [10:0] cursor;
        logic [15:0] word;
    } console_row_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [3:0]  cfg_wr_data  = 4'd0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action     = 2'd0;
    logic [7:0]  s_char_code  = 8'd0;
    logic [10:0] s_cell_index = 11'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [10:0] m_cursor_position;
    logic [15:0] m_cell_word;

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_char_code       (s_char_code),
        .s_cell_index      (s_cell_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_word       (m_cell_word)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    // console state as the block should hold it
    logic [15:0]    screen_cells [0:CELL_COUNT-1];
    int             console_cursor = 0;
    logic [3:0]     fg_color = FG_RESET;
    logic [3:0]     bg_color = BG_RESET;
    console_reply_t awaited_replies [$];

    int mismatches     = 0;
    int replies_seen   = 0;
    int quiet_cycles   = 0;
    int rx_gap         = 0;
    int literal_count  = 0;
    int newline_count  = 0;
    int tab_count      = 0;
    int read_count     = 0;
    int clear_count    = 0;
    int unused_count   = 0;
    int scroll_count   = 0;
    int items_sent     = 0;

    console_row_t directed_rows [21] = '{
        '{ACT_READ,   8'h00,        11'd2047, 1'b1, 11'd0,   16'h0000},
        '{ACT_UNUSED, 8'hFF,        11'd2047, 1'b1, 11'd0,   16'h0000},
        '{ACT_CLEAR,  8'h00,        11'd0,    1'b1, 11'd0,   16'h0000},
        '{ACT_READ,   8'h00,        11'd0,    1'b1, 11'd0,   16'h0020},
        '{ACT_READ,   8'hFF,        11'd1999, 1'b1, 11'd0,   16'h0020},
        '{ACT_PUT,    8'h00,        11'd0,    1'b1, 11'd1,   16'h0000},
        '{ACT_PUT,    8'hFF,        11'd2047, 1'b1, 11'd2,   16'h0000},
        '{ACT_READ,   8'h00,        11'd0,    1'b1, 11'd2,   16'h0700},
        '{ACT_READ,   8'h00,        11'd1,    1'b1, 11'd2,   16'h07FF},
        '{ACT_PUT,    CHAR_TAB,     11'd0,    1'b1, 11'd4,   16'h0000},
        '{ACT_PUT,    CHAR_TAB,     11'd0,    1'b1, 11'd8,   16'h0000},
        '{ACT_READ,   8'h00,        11'd3,    1'b1, 11'd8,   16'h0720},
        '{ACT_PUT,    8'h41,        11'd0,    1'b0, 11'd0,   16'h0000},
        '{ACT_PUT,    8'h0B,        11'd0,    1'b0, 11'd0,   16'h0000},
        '{ACT_PUT,    8'h08,        11'd0,    1'b0, 11'd0,   16'h0000},
        '{ACT_PUT,    CHAR_NEWLINE, 11'd0,    1'b1, 11'd80,  16'h0000},
        '{ACT_PUT,    CHAR_NEWLINE, 11'd1024, 1'b1, 11'd160, 16'h0000},
        '{ACT_READ,   8'h00,        11'd159,  1'b1, 11'd160, 16'h0720},
        '{ACT_READ,   8'h00,        11'd2000, 1'b1, 11'd160, 16'h0000},
        '{ACT_READ,   8'h00,        11'd8,    1'b0, 11'd0,   16'h0000},
        '{ACT_UNUSED, 8'h00,        11'd0,    1'b1, 11'd160, 16'h0000}
    };

    function automatic void scroll_screen();
        int k;
        for (k = 0; k < CELL_COUNT - COLUMNS; k++)
            screen_cells[k] = screen_cells[k + COLUMNS];
        for (k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
            screen_cells[k] = PLAIN_BLANK;
        console_cursor = CELL_COUNT - COLUMNS;
        scroll_count++;
    endfunction

    function automatic void store_char(input logic [7:0] ch);
        if (console_cursor >= CELL_COUNT)
            scroll_screen();
        screen_cells[console_cursor] = {bg_color, fg_color, ch};
        console_cursor++;
    endfunction

    function automatic console_reply_t advance_console(input console_item_t it);
        console_reply_t reply;
        logic [15:0]    cell_value;
        int             k;
        cell_value = 16'h0000;
        case (it.action)
            ACT_PUT: begin
                if (it.ch == CHAR_NEWLINE) begin
                    k = 0;
                    do begin
                        store_char(CHAR_SPACE);
                        k++;
                    end while ((console_cursor % COLUMNS) != 0 && k < COLUMNS);
                    newline_count++;
                end else if (it.ch == CHAR_TAB) begin
                    k = 0;
                    do begin
                        store_char(CHAR_SPACE);
                        k++;
                    end while ((console_cursor % TAB_STOP) != 0 && k < COLUMNS + TAB_STOP);
                    tab_count++;
                end else begin
                    store_char(it.ch);
                    literal_count++;
                end
            end
            ACT_CLEAR: begin
                for (k = 0; k < CELL_COUNT; k++)
                    screen_cells[k] = PLAIN_BLANK;
                console_cursor = 0;
                clear_count++;
            end
            ACT_READ: begin
                if (it.idx < CELL_COUNT)
                    cell_value = screen_cells[it.idx];
                read_count++;
            end
            default: begin
                unused_count++;
            end
        endcase
        reply.cursor = 11'(console_cursor);
        reply.word   = cell_value;
        return reply;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    // text-like traffic: many newlines so the cursor reaches the bottom and scrolls
    function automatic console_item_t random_item(input bit allow_clear);
        console_item_t it;
        int            r;
        int            sub;
        r         = $urandom_range(0, 99);
        it.ch     = 8'($urandom_range(0, 255));
        it.idx    = 11'($urandom_range(0, 2047));
        it.action = ACT_PUT;
        if (r < 2) begin
            it.action = ACT_UNUSED;
        end else if (allow_clear && r < 5) begin
            it.action = ACT_CLEAR;
        end else if (r < 33) begin
            // every cell has been written since the clear in the directed part
            it.action = ACT_READ;
            if ($urandom_range(0, 9) == 0)
                it.idx = 11'($urandom_range(CELL_COUNT, 2047));
            else
                it.idx = 11'($urandom_range(0, CELL_COUNT - 1));
        end else begin
            sub = $urandom_range(0, 99);
            if (sub < 45)
                it.ch = CHAR_NEWLINE;
            else if (sub < 60)
                it.ch = CHAR_TAB;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // returns at the edge where the item transfers
    task automatic offer(input console_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= it.action;
        s_char_code  <= it.ch;
        s_cell_index <= it.idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_FOREGROUND;
        cfg_wr_data <= fg;
        @(posedge aclk);
        fg_color     = fg;
        cfg_index   <= CFG_BACKGROUND;
        cfg_wr_data <= bg;
        @(posedge aclk);
        bg_color   = bg;
        cfg_wr_en <= 1'b0;
    endtask

    // result side: compare against the oldest prediction, then choose the next stall
    always @(posedge aclk) begin
        console_reply_t want;
        bit             steady;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            steady = (replies_seen >= 120 && replies_seen < 170);
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, cursor %0d cell %h",
                                              m_cursor_position, m_cell_word));
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_cursor_position !== want.cursor)
                        report_mismatch($sformatf("reply %0d cursor %0d, expected %0d",
                                                  replies_seen, m_cursor_position, want.cursor));
                    if (m_cell_word !== want.word)
                        report_mismatch($sformatf("reply %0d cell %h, expected %h",
                                                  replies_seen, m_cell_word, want.word));
                end
                replies_seen++;
                if (replies_seen == 60)
                    rx_gap = LONG_HOLD;
                else
                    rx_gap = steady ? 0 : pick_gap();
            end else if (rx_gap == 0 && !steady && $urandom_range(0, 19) == 0) begin
                rx_gap = pick_gap();
            end
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles, %0d replies still awaited",
                     quiet_cycles, awaited_replies.size());
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    initial begin
        console_item_t it;
        console_reply_t reply;
        int             i;
        int             phase;
        logic [3:0]     fg;
        logic [3:0]     bg;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            it.action = directed_rows[i].action;
            it.ch     = directed_rows[i].ch;
            it.idx    = directed_rows[i].idx;
            offer(it, pick_gap());
            reply = advance_console(it);
            if (directed_rows[i].typed) begin
                reply.cursor = directed_rows[i].cursor;
                reply.word   = directed_rows[i].word;
            end
            awaited_replies.push_back(reply);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_until_idle();
            case (phase)
                0: begin fg = 4'd15; bg = 4'd15; end
                1: begin fg = 4'd0;  bg = 4'd0;  end
                3: begin fg = 4'($urandom_range(0, 15)); bg = 4'd15; end
                default: begin
                    fg = 4'($urandom_range(0, 15));
                    bg = 4'($urandom_range(0, 15));
                end
            endcase
            write_colors(fg, bg);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                it = random_item(phase >= 3);
                // phase 1 runs back to back on the input side
                offer(it, (phase == 1) ? 0 : pick_gap());
                awaited_replies.push_back(advance_console(it));
            end
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (awaited_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));

        $display("covered %0d items: %0d chars, %0d nl, %0d tabs, %0d reads, %0d clr, %0d unused",
                 items_sent, literal_count, newline_count, tab_count, read_count,
                 clear_count, unused_count);
        $display("screen scrolled %0d times over %0d color settings, %0d replies checked",
                 scroll_count, PHASES + 1, replies_seen);
        if (mismatches == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL text_console_writer");
        end
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
sim/text_console_writer_test.sv
